### rtl/sst_pkg.sv
// Shared constants for the speech segment tracker.
`default_nettype none

package sst_pkg;

   // Default parameter values for the top level.
   localparam int SST_WINDOW_SAMPLES_DEF = 512;
   localparam int SST_SAMPLE_RATE_DEF    = 16000;

   // Sample positions and millisecond results.
   localparam int SAMP_W      = 32;
   localparam int MS_W        = 28;
   localparam int MS_PER_SEC  = 1000;
   localparam int MS_PER_SEC_W = 10;
   localparam int X_W         = SAMP_W + MS_PER_SEC_W;
   localparam logic [MS_W-1:0] SST_MS_MAX = '1;

   // Silence in milliseconds that marks a usable split point.
   localparam int SPLIT_SILENCE_MS = 98;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_THRESHOLD   = 3'd0,
      REG_BOUNDARY    = 3'd1,
      REG_MIN_SILENCE = 3'd2,
      REG_MIN_SPEECH  = 3'd3,
      REG_MAX_SPEECH  = 3'd4,
      REG_PAD_START   = 3'd5,
      REG_PAD_END     = 3'd6,
      REG_AUDIO_LEN   = 3'd7
   } reg_idx_type;

   // Input item operations.
   typedef enum logic {
      OP_WINDOW = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

endpackage : sst_pkg

`default_nettype wire

### rtl/sst_ms_conv.sv
// Two-stage sample count to millisecond converter, reciprocal multiply with correction.
`default_nettype none

module sst_ms_conv
   import sst_pkg::*;
#(
   parameter int SAMPLE_RATE = SST_SAMPLE_RATE_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_vld,
   input  wire logic [SAMP_W-1:0] in_samples,
   output logic                   out_vld,
   output logic [MS_W-1:0]        out_ms
);

   // floor(MS_PER_SEC * 2^SAMP_W / SAMPLE_RATE): the estimate is low by at most one
   localparam logic [63:0] RECIP    = (64'(MS_PER_SEC) << SAMP_W) / 64'(SAMPLE_RATE);
   localparam int          RECIP_W  = $clog2(RECIP + 64'd1);
   localparam int          PROD_W   = SAMP_W + RECIP_W;
   localparam int          QF_W     = RECIP_W + 1;
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP[RECIP_W-1:0];

   logic              vld_a_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [X_W-1:0]    scaled_ff;
   logic [X_W-1:0]    scaled_in;

   logic [RECIP_W-1:0] q_est;
   logic [X_W-1:0]     q_back;
   logic [X_W-1:0]     rem;
   logic               corr;
   logic [QF_W-1:0]    q_full;
   logic [SAMP_W-1:0]  q_wide;
   logic [MS_W-1:0]    ms_in;
   logic               vld_b_ff;
   logic [MS_W-1:0]    ms_ff;

   // stage A: estimate and exact scaled value
   assign prod_in   = PROD_W'(in_samples) * PROD_W'(RECIP_C);
   assign scaled_in = X_W'(in_samples) * X_W'(MS_PER_SEC);

   // stage B: remainder check, one step of correction, saturate
   always_comb begin
      q_est  = prod_ff[PROD_W-1:SAMP_W];
      q_back = X_W'(q_est) * X_W'(SAMPLE_RATE);
      rem    = scaled_ff - q_back;
      corr   = (rem >= X_W'(SAMPLE_RATE));
      q_full = QF_W'(q_est) + QF_W'(corr);
      q_wide = SAMP_W'(q_full);
      ms_in  = (q_wide > SAMP_W'(SST_MS_MAX)) ? SST_MS_MAX : q_wide[MS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         vld_a_ff <= in_vld;
         vld_b_ff <= vld_a_ff;
      end
      prod_ff   <= prod_in;
      scaled_ff <= scaled_in;
      ms_ff     <= ms_in;
   end

   assign out_vld = vld_b_ff;
   assign out_ms  = ms_ff;

endmodule : sst_ms_conv

`default_nettype wire

### rtl/speech_segment_tracker_top.sv
// Speech segment tracker: window decisions, padding, ms conversion and result queue.
// Path: an accepted item passes the input register, decision, padding, two
//   conversion stages, the queue and the output register to its result.
// Throughput: one item per cycle; the outstanding-item credit (8) sets the limit.
// Items that close no segment produce nothing and free their credit after decision.
// Reset (synchronous, active high) clears tracker state, queue, credits and
// loads register defaults.
`default_nettype none

module speech_segment_tracker_top
   import sst_pkg::*;
#(
   parameter int WINDOW_SAMPLES = SST_WINDOW_SAMPLES_DEF,
   parameter int SAMPLE_RATE    = SST_SAMPLE_RATE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   input  wire logic [15:0] req_speech_probability,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [MS_W-1:0]  rsp_start_ms,
   output logic [MS_W-1:0]  rsp_end_ms,
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // ------------------------------------------------------------------
   // Local constants
   // ------------------------------------------------------------------
   localparam logic [SAMP_W-1:0] WIN_C      = SAMP_W'(WINDOW_SAMPLES);
   localparam logic [SAMP_W-1:0] SAT_LIMIT  = '1 - WIN_C;
   localparam logic [SAMP_W-1:0] SPLIT_SIL  =
      SAMP_W'((SAMPLE_RATE / MS_PER_SEC) * SPLIT_SILENCE_MS);
   localparam int                DEPTH      = 8;
   localparam int                PTR_W      = $clog2(DEPTH);
   localparam int                CNT_W      = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [MS_W-1:0] start_ms;
      logic [MS_W-1:0] end_ms;
   } seg_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [15:0]       threshold_ff;
   logic [15:0]       boundary_ff;
   logic [SAMP_W-1:0] min_silence_ff;
   logic [SAMP_W-1:0] min_speech_ff;
   logic [SAMP_W-1:0] max_speech_ff;
   logic [SAMP_W-1:0] pad_start_ff;
   logic [SAMP_W-1:0] pad_end_ff;
   logic [SAMP_W-1:0] audio_len_ff;

   logic        csr_wr;
   reg_idx_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= 16'd16384;
         boundary_ff    <= 16'd4915;
         min_silence_ff <= 32'd1600;
         min_speech_ff  <= 32'd4000;
         max_speech_ff  <= '1;
         pad_start_ff   <= 32'd480;
         pad_end_ff     <= '0;
         audio_len_ff   <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_THRESHOLD:   threshold_ff   <= csr_pwdata[15:0];
            REG_BOUNDARY:    boundary_ff    <= csr_pwdata[15:0];
            REG_MIN_SILENCE: min_silence_ff <= csr_pwdata;
            REG_MIN_SPEECH:  min_speech_ff  <= csr_pwdata;
            REG_MAX_SPEECH:  max_speech_ff  <= csr_pwdata;
            REG_PAD_START:   pad_start_ff   <= csr_pwdata;
            REG_PAD_END:     pad_end_ff     <= csr_pwdata;
            REG_AUDIO_LEN:   audio_len_ff   <= csr_pwdata;
            default:         ;
         endcase
      end
   end

   // read back; the 16-bit registers come back zero-extended
   always_comb begin
      unique case (csr_idx)
         REG_THRESHOLD:   csr_prdata = {16'd0, threshold_ff};
         REG_BOUNDARY:    csr_prdata = {16'd0, boundary_ff};
         REG_MIN_SILENCE: csr_prdata = min_silence_ff;
         REG_MIN_SPEECH:  csr_prdata = min_speech_ff;
         REG_MAX_SPEECH:  csr_prdata = max_speech_ff;
         REG_PAD_START:   csr_prdata = pad_start_ff;
         REG_PAD_END:     csr_prdata = pad_end_ff;
         REG_AUDIO_LEN:   csr_prdata = audio_len_ff;
         default:         csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Credit: every accepted item holds one until it is dropped at the
   // decision stage or its result is taken. The queue can never overflow.
   // ------------------------------------------------------------------
   logic             req_acc;
   logic             rsp_acc;
   logic             drop;
   logic [CNT_W-1:0] pending_ff;
   logic [CNT_W-1:0] pending_in;

   assign req_ready  = (pending_ff < CNT_W'(DEPTH));
   assign req_acc    = req_valid && req_ready;
   assign rsp_acc    = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + CNT_W'(req_acc) - CNT_W'(rsp_acc) - CNT_W'(drop);

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic        in_vld_ff;
   op_type      in_op_ff;
   logic [15:0] in_prob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         pending_ff <= '0;
      end else begin
         in_vld_ff  <= req_acc;
         pending_ff <= pending_in;
      end
      if (req_acc) begin
         in_op_ff   <= op_type'(req_operation);
         in_prob_ff <= req_speech_probability;
      end
   end

   // ------------------------------------------------------------------
   // Decision stage: tracker state and segment closing
   // ------------------------------------------------------------------
   logic              triggered_ff,  triggered_in;
   logic              seg_open_ff,   seg_open_in;
   logic [SAMP_W-1:0] sample_pos_ff, sample_pos_in;
   logic [SAMP_W-1:0] tent_end_ff,   tent_end_in;
   logic [SAMP_W-1:0] prev_end_ff,   prev_end_in;
   logic [SAMP_W-1:0] next_start_ff, next_start_in;
   logic [SAMP_W-1:0] seg_start_ff,  seg_start_in;

   logic              emit_vld_ff,   emit_vld_in;
   logic [SAMP_W-1:0] emit_s_ff,     emit_s_in;
   logic [SAMP_W-1:0] emit_e_ff,     emit_e_in;

   logic [SAMP_W-1:0] sp_next;
   logic [SAMP_W-1:0] win_start;
   logic              above;
   logic              in_band;
   logic              split_due;
   logic [SAMP_W-1:0] te_eff;
   logic [SAMP_W-1:0] quiet;
   logic              seg_long;

   always_comb begin
      triggered_in  = triggered_ff;
      seg_open_in   = seg_open_ff;
      sample_pos_in = sample_pos_ff;
      tent_end_in   = tent_end_ff;
      prev_end_in   = prev_end_ff;
      next_start_in = next_start_ff;
      seg_start_in  = seg_start_ff;
      emit_vld_in   = 1'b0;
      emit_s_in     = seg_start_ff;
      emit_e_in     = audio_len_ff;

      // advance the position by one window, saturating
      sp_next   = (sample_pos_ff > SAT_LIMIT) ? '1 : sample_pos_ff + WIN_C;
      win_start = sp_next - WIN_C;

      above   = (in_prob_ff >= threshold_ff);
      // prob >= threshold - offset, kept non-negative by moving the offset across
      in_band = ((17'(in_prob_ff) + 17'(boundary_ff)) >= 17'(threshold_ff));
      split_due = ((sp_next - seg_start_ff) > max_speech_ff) && (sp_next >= seg_start_ff);

      te_eff   = (tent_end_ff == '0) ? sp_next : tent_end_ff;
      quiet    = sp_next - te_eff;
      seg_long = (te_eff > seg_start_ff) && ((te_eff - seg_start_ff) > min_speech_ff);

      if (in_vld_ff) begin
         if (in_op_ff == OP_FINISH) begin
            // close any open segment at the clip end, then start a new clip
            emit_vld_in   = seg_open_ff;
            emit_s_in     = seg_start_ff;
            emit_e_in     = audio_len_ff;
            triggered_in  = 1'b0;
            seg_open_in   = 1'b0;
            sample_pos_in = '0;
            tent_end_in   = '0;
            prev_end_in   = '0;
            next_start_in = '0;
            seg_start_in  = '0;
         end else begin
            sample_pos_in = sp_next;
            if (above) begin
               // speech: cancel a pending end, open a segment if idle
               if (tent_end_ff != '0) begin
                  tent_end_in = '0;
                  if (next_start_ff < prev_end_ff) begin
                     next_start_in = win_start;
                  end
               end
               if (!triggered_ff) begin
                  triggered_in = 1'b1;
                  seg_open_in  = 1'b1;
                  seg_start_in = win_start;
               end
            end else if (triggered_ff && seg_open_ff && split_due) begin
               // too long: split at the last quiet point, or here
               emit_vld_in = 1'b1;
               emit_s_in   = seg_start_ff;
               if (prev_end_ff != '0) begin
                  emit_e_in = prev_end_ff;
                  if (next_start_ff < prev_end_ff) begin
                     triggered_in = 1'b0;
                     seg_open_in  = 1'b0;
                  end else begin
                     seg_start_in = next_start_ff;
                  end
               end else begin
                  emit_e_in    = sp_next;
                  triggered_in = 1'b0;
                  seg_open_in  = 1'b0;
               end
               prev_end_in   = '0;
               next_start_in = '0;
               tent_end_in   = '0;
            end else if (!in_band && triggered_ff) begin
               // silence while triggered: track it, close after enough of it
               tent_end_in = te_eff;
               if (quiet > SPLIT_SIL) begin
                  prev_end_in = te_eff;
               end
               if (quiet >= min_silence_ff) begin
                  emit_vld_in   = seg_open_ff && seg_long;
                  emit_s_in     = seg_start_ff;
                  emit_e_in     = te_eff;
                  seg_open_in   = 1'b0;
                  triggered_in  = 1'b0;
                  prev_end_in   = '0;
                  next_start_in = '0;
                  tent_end_in   = '0;
               end
            end
         end
      end
   end

   assign drop = in_vld_ff && !emit_vld_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         triggered_ff  <= 1'b0;
         seg_open_ff   <= 1'b0;
         sample_pos_ff <= '0;
         tent_end_ff   <= '0;
         prev_end_ff   <= '0;
         next_start_ff <= '0;
         seg_start_ff  <= '0;
         emit_vld_ff   <= 1'b0;
      end else begin
         triggered_ff  <= triggered_in;
         seg_open_ff   <= seg_open_in;
         sample_pos_ff <= sample_pos_in;
         tent_end_ff   <= tent_end_in;
         prev_end_ff   <= prev_end_in;
         next_start_ff <= next_start_in;
         seg_start_ff  <= seg_start_in;
         emit_vld_ff   <= emit_vld_in;
      end
      emit_s_ff <= emit_s_in;
      emit_e_ff <= emit_e_in;
   end

   // ------------------------------------------------------------------
   // Padding stage: start floored at zero, end clamped at the clip length
   // ------------------------------------------------------------------
   logic              pad_vld_ff;
   logic [SAMP_W-1:0] pad_a_ff, pad_a_in;
   logic [SAMP_W-1:0] pad_b_ff, pad_b_in;
   logic [SAMP_W:0]   end_sum;

   always_comb begin
      pad_a_in = (emit_s_ff > pad_start_ff) ? emit_s_ff - pad_start_ff : '0;
      end_sum  = {1'b0, emit_e_ff} + {1'b0, pad_end_ff};
      pad_b_in = (end_sum > {1'b0, audio_len_ff}) ? audio_len_ff : end_sum[SAMP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_vld_ff <= 1'b0;
      end else begin
         pad_vld_ff <= emit_vld_ff;
      end
      pad_a_ff <= pad_a_in;
      pad_b_ff <= pad_b_in;
   end

   // ------------------------------------------------------------------
   // Millisecond conversion, one unit per field
   // ------------------------------------------------------------------
   logic            conv_vld;
   logic            conv_vld_unused;
   logic [MS_W-1:0] conv_start_ms;
   logic [MS_W-1:0] conv_end_ms;

   sst_ms_conv #(
      .SAMPLE_RATE (SAMPLE_RATE)
   ) u_conv_start (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (pad_vld_ff),
      .in_samples (pad_a_ff),
      .out_vld    (conv_vld),
      .out_ms     (conv_start_ms)
   );

   sst_ms_conv #(
      .SAMPLE_RATE (SAMPLE_RATE)
   ) u_conv_end (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (pad_vld_ff),
      .in_samples (pad_b_ff),
      .out_vld    (conv_vld_unused),
      .out_ms     (conv_end_ms)
   );

   // ------------------------------------------------------------------
   // Result queue and output register
   // ------------------------------------------------------------------
   seg_type          fifo_mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] fifo_cnt_ff;
   logic             fifo_wr;
   logic             fifo_rd;
   logic             rsp_vld_ff;
   seg_type          rsp_seg_ff;

   assign fifo_wr = conv_vld && conv_vld_unused;
   assign fifo_rd = (fifo_cnt_ff != '0) && (!rsp_vld_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (fifo_wr) begin
         fifo_mem[wr_ptr_ff] <= '{start_ms: conv_start_ms, end_ms: conv_end_ms};
      end
      if (fifo_rd) begin
         rsp_seg_ff <= fifo_mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (fifo_wr) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (fifo_rd) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         fifo_cnt_ff <= fifo_cnt_ff + CNT_W'(fifo_wr) - CNT_W'(fifo_rd);
         // load on a pop, drop once taken
         if (fifo_rd) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_start_ms = rsp_seg_ff.start_ms;
   assign rsp_end_ms   = rsp_seg_ff.end_ms;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`ifndef ASSERT_OFF
   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (fifo_wr && !fifo_rd) |-> (fifo_cnt_ff < CNT_W'(DEPTH)))
      else $error("result queue written while full");

   a_credit_covers_queue: assert property (@(posedge clock) disable iff (reset)
      pending_ff >= fifo_cnt_ff)
      else $error("queued results exceed outstanding credit");

   a_open_tracks_trigger: assert property (@(posedge clock) disable iff (reset)
      seg_open_ff == triggered_ff)
      else $error("segment open flag out of step with trigger");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && (in_op_ff == OP_FINISH)) |=>
         (!triggered_ff && (sample_pos_ff == '0) && (tent_end_ff == '0)))
      else $error("finish item did not clear tracker state");
`endif

endmodule : speech_segment_tracker_top

`default_nettype wire

### verif/testbench.sv
// Self-checking bench for speech_segment_tracker_top: predicts segments per item, checks each result.
`timescale 1ns / 100ps

module testbench
   import sst_pkg::*;
();

   // ---------------------------------------------------------------------
   // Constants of the bench
   // ---------------------------------------------------------------------
   localparam logic [31:0] WIN_SAMPLES    = 32'(SST_WINDOW_SAMPLES_DEF);
   localparam logic [63:0] RATE_HZ        = 64'(SST_SAMPLE_RATE_DEF);
   localparam logic [31:0] SAMPLE_CEILING = 32'hFFFF_FFFF;
   // Silence beyond this many samples marks a usable split point.
   localparam logic [31:0] SPLIT_QUIET_SAMPLES =
      32'((SST_SAMPLE_RATE_DEF / MS_PER_SEC) * SPLIT_SILENCE_MS);
   localparam int SETTLE_CYCLES    = 16;   // covers the block's pipeline with margin
   localparam int LONG_HOLD_CYCLES = 300;  // long enough to exhaust the 8 item credits
   localparam int RUN_LIMIT_NS     = 4_000_000;

   typedef enum int {
      PROB_SPEECH,
      PROB_BAND,
      PROB_QUIET,
      PROB_NOISE
   } prob_kind_type;

   typedef struct packed {
      logic [MS_W-1:0] start_ms;
      logic [MS_W-1:0] end_ms;
   } segment_type;

   // ---------------------------------------------------------------------
   // Block ports
   // ---------------------------------------------------------------------
   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic            req_operation = 1'b0;
   logic [15:0]     req_speech_probability = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [MS_W-1:0] rsp_start_ms;
   logic [MS_W-1:0] rsp_end_ms;
   logic            csr_psel = 1'b0;
   logic            csr_penable = 1'b0;
   logic            csr_pwrite = 1'b0;
   logic [4:0]      csr_paddr = '0;
   logic [31:0]     csr_pwdata = '0;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   speech_segment_tracker_top DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_operation          (req_operation),
      .req_speech_probability (req_speech_probability),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_start_ms           (rsp_start_ms),
      .rsp_end_ms             (rsp_end_ms),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor copy of the register file (reset values)
   // ---------------------------------------------------------------------
   logic [15:0] cfg_threshold    = 16'd16384;
   logic [15:0] cfg_boundary     = 16'd4915;
   logic [31:0] cfg_min_silence  = 32'd1600;
   logic [31:0] cfg_min_speech   = 32'd4000;
   logic [31:0] cfg_max_speech   = 32'hFFFF_FFFF;
   logic [31:0] cfg_pad_start    = 32'd480;
   logic [31:0] cfg_pad_end      = 32'd0;
   logic [31:0] cfg_audio_length = 32'd0;

   // Predictor copy of the tracker state
   logic        trk_triggered  = 1'b0;
   logic        trk_open       = 1'b0;
   logic [31:0] trk_pos        = '0;
   logic [31:0] trk_tent_end   = '0;   // zero means no tentative end
   logic [31:0] trk_prev_end   = '0;   // zero means no split point
   logic [31:0] trk_next_start = '0;
   logic [31:0] trk_seg_start  = '0;

   segment_type expected_segments[$];

   // Run bookkeeping
   bit idle_on = 1'b1;
   int holds_asked = 0;
   int holds_done = 0;
   int mismatch_count = 0;
   int items_sent = 0;
   int segments_checked = 0;
   int config_sets = 0;

   // ---------------------------------------------------------------------
   // Segment predictor
   // ---------------------------------------------------------------------
   function automatic logic [MS_W-1:0] samples_to_ms(input logic [63:0] samples);
      logic [63:0] ms;
      ms = samples * 64'(MS_PER_SEC) / RATE_HZ;
      return (ms > 64'(SST_MS_MAX)) ? SST_MS_MAX : ms[MS_W-1:0];
   endfunction

   // Pad the start down (floored at 0), pad the end up (clamped to the clip), queue it.
   function automatic void push_segment(input logic [31:0] seg_from, input logic [31:0] seg_to);
      logic [63:0] first;
      logic [63:0] last;
      segment_type seg;
      first = (seg_from > cfg_pad_start) ? 64'(seg_from - cfg_pad_start) : 64'd0;
      last  = 64'(seg_to) + 64'(cfg_pad_end);
      if (last > 64'(cfg_audio_length)) begin
         last = 64'(cfg_audio_length);
      end
      seg.start_ms = samples_to_ms(first);
      seg.end_ms   = samples_to_ms(last);
      expected_segments = {expected_segments, seg};
   endfunction

   function automatic void clear_tracker();
      trk_triggered  = 1'b0;
      trk_open       = 1'b0;
      trk_pos        = '0;
      trk_tent_end   = '0;
      trk_prev_end   = '0;
      trk_next_start = '0;
      trk_seg_start  = '0;
   endfunction

   function automatic void track_item(input op_type op, input logic [15:0] prob);
      logic [31:0] win_start;
      logic [31:0] span;
      logic [31:0] quiet;
      longint      lower;
      longint      seg_len;
      lower = longint'(cfg_threshold) - longint'(cfg_boundary);

      // Finish closes the open segment at the clip end, with no length check.
      if (op == OP_FINISH) begin
         if (trk_open) begin
            push_segment(trk_seg_start, cfg_audio_length);
         end
         clear_tracker();
         return;
      end

      // Advance the position, saturating at the top of 32 bits.
      if (trk_pos > SAMPLE_CEILING - WIN_SAMPLES) begin
         trk_pos = SAMPLE_CEILING;
      end else begin
         trk_pos = trk_pos + WIN_SAMPLES;
      end
      win_start = trk_pos - WIN_SAMPLES;

      // Speech: cancel a pending end, open a segment if none is running.
      if (prob >= cfg_threshold) begin
         if (trk_tent_end != 0) begin
            trk_tent_end = '0;
            if (trk_next_start < trk_prev_end) begin
               trk_next_start = win_start;
            end
         end
         if (!trk_triggered) begin
            trk_triggered = 1'b1;
            trk_open      = 1'b1;
            trk_seg_start = win_start;
         end
         return;
      end

      // Maximum length reached: split at the last usable silence, else cut here.
      span = trk_pos - trk_seg_start;
      if (trk_triggered && trk_open && span > cfg_max_speech && trk_pos >= trk_seg_start) begin
         if (trk_prev_end != 0) begin
            push_segment(trk_seg_start, trk_prev_end);
            if (trk_next_start < trk_prev_end) begin
               trk_triggered = 1'b0;
               trk_open      = 1'b0;
            end else begin
               trk_seg_start = trk_next_start;
            end
         end else begin
            push_segment(trk_seg_start, trk_pos);
            trk_triggered = 1'b0;
            trk_open      = 1'b0;
         end
         trk_prev_end   = '0;
         trk_next_start = '0;
         trk_tent_end   = '0;
         return;
      end

      // Inside the band below the threshold: no decision.
      if (longint'(prob) >= lower) begin
         return;
      end

      // Silence: close once it has lasted long enough, keep only long segments.
      if (trk_triggered) begin
         if (trk_tent_end == 0) begin
            trk_tent_end = trk_pos;
         end
         quiet = trk_pos - trk_tent_end;
         if (quiet > SPLIT_QUIET_SAMPLES) begin
            trk_prev_end = trk_tent_end;
         end
         if (quiet >= cfg_min_silence) begin
            seg_len = longint'(trk_tent_end) - longint'(trk_seg_start);
            if (trk_open && seg_len > longint'(cfg_min_speech)) begin
               push_segment(trk_seg_start, trk_tent_end);
            end
            trk_open       = 1'b0;
            trk_triggered  = 1'b0;
            trk_prev_end   = '0;
            trk_next_start = '0;
            trk_tent_end   = '0;
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Result checking: compare every accepted result with the oldest expectation
   // ---------------------------------------------------------------------
   function automatic void note_mismatch(input string what, input logic [MS_W-1:0] want,
                                         input logic [MS_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin
      segment_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_segments.size() == 0) begin
            note_mismatch("start_ms of a segment nobody expected", '0, rsp_start_ms);
         end else begin
            due = expected_segments.pop_front();
            segments_checked++;
            if (rsp_start_ms !== due.start_ms) begin
               note_mismatch("start_ms", due.start_ms, rsp_start_ms);
            end
            if (rsp_end_ms !== due.end_ms) begin
               note_mismatch("end_ms", due.end_ms, rsp_end_ms);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result side: random stall bursts, plus a long hold on request
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (holds_asked != holds_done) begin
            // Hold off long enough that the block runs out of credit and stalls its input.
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
         end else if (idle_on && rsp_ready && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Offer one item; return at the edge where it is accepted, valid left high.
   task automatic send_item(input op_type op, input logic [15:0] prob);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid              <= 1'b1;
      req_operation          <= op;
      req_speech_probability <= prob;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      track_item(op, prob);
   endtask

   // Drop valid, wait for every expected segment, then let the pipeline empty.
   task automatic wait_segments_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input reg_idx_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(4 * int'(idx));
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_THRESHOLD:   cfg_threshold    = value[15:0];
         REG_BOUNDARY:    cfg_boundary     = value[15:0];
         REG_MIN_SILENCE: cfg_min_silence  = value;
         REG_MIN_SPEECH:  cfg_min_speech   = value;
         REG_MAX_SPEECH:  cfg_max_speech   = value;
         REG_PAD_START:   cfg_pad_start    = value;
         REG_PAD_END:     cfg_pad_end      = value;
         REG_AUDIO_LEN:   cfg_audio_length = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Rewrite the whole register file once the block has gone idle.
   task automatic set_config(input logic [31:0] threshold, input logic [31:0] boundary,
                             input logic [31:0] min_silence, input logic [31:0] min_speech,
                             input logic [31:0] max_speech, input logic [31:0] pad_start,
                             input logic [31:0] pad_end, input logic [31:0] audio_length);
      wait_segments_drained();
      write_csr(REG_THRESHOLD, threshold);
      write_csr(REG_BOUNDARY, boundary);
      write_csr(REG_MIN_SILENCE, min_silence);
      write_csr(REG_MIN_SPEECH, min_speech);
      write_csr(REG_MAX_SPEECH, max_speech);
      write_csr(REG_PAD_START, pad_start);
      write_csr(REG_PAD_END, pad_end);
      write_csr(REG_AUDIO_LEN, audio_length);
      config_sets++;
   endtask

   // Pick a probability of the wanted class under the current settings.
   function automatic logic [15:0] pick_probability(input prob_kind_type kind);
      int lower;
      int band_lo;
      lower = int'(cfg_threshold) - int'(cfg_boundary);
      case (kind)
         PROB_SPEECH: begin
            if (cfg_threshold > 16'd32768 || $urandom_range(0, 15) == 0) begin
               return 16'($urandom_range(int'(cfg_threshold), 65535));
            end
            return 16'($urandom_range(int'(cfg_threshold), 32768));
         end
         PROB_BAND: begin
            band_lo = (lower < 0) ? 0 : lower;
            if (cfg_threshold != 0 && band_lo < int'(cfg_threshold)) begin
               return 16'($urandom_range(band_lo, int'(cfg_threshold) - 1));
            end
         end
         PROB_QUIET: begin
            if (lower > 0) begin
               return 16'($urandom_range(0, lower - 1));
            end
         end
         default: ;
      endcase
      return 16'($urandom);
   endfunction

   // Mostly well-formed talk: speech runs, a few band windows, then silence;
   // sprinkle noise and finish items in between.
   task automatic send_stream(input int count, input int speech_max, input int quiet_max);
      int sent;
      int run;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 19);
         if (pick < 2) begin
            send_item(OP_FINISH, 16'($urandom));
            sent++;
         end else if (pick < 4) begin
            run = $urandom_range(1, 4);
            repeat (run) send_item(OP_WINDOW, pick_probability(PROB_NOISE));
            sent += run;
         end else begin
            run = $urandom_range(1, speech_max);
            repeat (run) send_item(OP_WINDOW, pick_probability(PROB_SPEECH));
            sent += run;
            run = $urandom_range(0, 2);
            repeat (run) send_item(OP_WINDOW, pick_probability(PROB_BAND));
            sent += run;
            run = $urandom_range(0, quiet_max);
            repeat (run) send_item(OP_WINDOW, pick_probability(PROB_QUIET));
            sent += run;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset settings: empty finish, field extremes, exact threshold and band edge,
   // and a finish whose clip end lies below the padded start.
   task automatic test_defaults_directed();
      send_item(OP_FINISH, 16'hFFFF);
      send_item(OP_WINDOW, 16'd0);
      send_item(OP_WINDOW, 16'd0);
      send_item(OP_WINDOW, 16'd32768);
      send_item(OP_WINDOW, 16'hFFFF);
      send_item(OP_WINDOW, 16'd16384);
      send_item(OP_WINDOW, 16'd11469);
      send_item(OP_WINDOW, 16'd11468);
      send_item(OP_FINISH, 16'd0);
   endtask

   // Band reaching below zero, zero silence and length limits, a split with no
   // silence point, and an end padded past the top of the clip.
   task automatic test_band_and_length_split();
      set_config(32'd1000, 32'd5000, 32'd0, 32'd0, 32'd1024, 32'd0, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
      send_item(OP_WINDOW, 16'd1000);
      send_item(OP_WINDOW, 16'd0);
      send_item(OP_WINDOW, 16'd999);
      send_item(OP_WINDOW, 16'd500);
      send_item(OP_FINISH, 16'h5A5A);
   endtask

   // A split that falls back to an earlier pause, then finish the remainder.
   task automatic test_split_at_pause();
      set_config(32'd32768, 32'd0, 32'd4000, 32'd0, 32'd4000, 32'hFFFF_FFFF, 32'd0,
                 32'd100000);
      send_item(OP_WINDOW, 16'd32768);
      repeat (5) send_item(OP_WINDOW, 16'd0);
      send_item(OP_WINDOW, 16'd32768);
      send_item(OP_WINDOW, 16'd0);
      send_item(OP_FINISH, 16'd0);
   endtask

   task automatic test_default_config_stream();
      set_config(32'd16384, 32'd4915, 32'd1600, 32'd4000, 32'hFFFF_FFFF, 32'd480, 32'd0,
                 32'd2_000_000);
      send_stream(250, 14, 8);
   endtask

   // Short segments close every few items; hold the result side off midway.
   task automatic test_short_segments_under_backpressure();
      set_config($urandom_range(4000, 28000), $urandom_range(0, 4000),
                 $urandom_range(0, 600), $urandom_range(0, 1500), 32'hFFFF_FFFF,
                 $urandom_range(0, 2000), $urandom_range(0, 2000),
                 $urandom_range(1_000_000, 4_000_000));
      send_stream(100, 4, 3);
      holds_asked++;
      send_stream(200, 4, 3);
   endtask

   // Long silences leave split points; pause the input halfway until all is out.
   task automatic test_length_splits();
      set_config($urandom_range(8000, 30000), $urandom_range(500, 8000),
                 $urandom_range(3000, 8000), $urandom_range(0, 3000),
                 $urandom_range(3000, 20000), $urandom_range(0, 1000),
                 $urandom_range(0, 1000), 32'd500_000);
      send_stream(175, 12, 14);
      wait_segments_drained();
      send_stream(175, 12, 14);
   endtask

   task automatic test_extreme_settings();
      // everything counts as speech
      set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
      send_stream(90, 6, 6);
      idle_on = 1'b0;
      // silence impossible, every non-speech window inside a segment cuts at maximum length zero
      set_config(32'd32768, 32'd32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_stream(90, 6, 6);
      idle_on = 1'b1;
      // silence never long enough, only finish closes
      set_config(32'd32768, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0,
                 32'hFFFF_FFFF);
      send_stream(90, 6, 6);
      // only zero is silence, nothing is long enough to keep, frequent splits
      set_config(32'd1, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd512, 32'd0, 32'd0, 32'd1);
      send_stream(90, 6, 6);
   endtask

   // Random settings over the full ranges; the last round runs without idling.
   task automatic test_mixed_settings();
      logic [31:0] min_silence;
      logic [31:0] min_speech;
      logic [31:0] max_speech;
      logic [31:0] pad_start;
      logic [31:0] pad_end;
      logic [31:0] audio_length;
      for (int round = 0; round < 5; round++) begin
         min_silence  = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5000);
         min_speech   = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6000);
         max_speech   = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF :
                        ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1024) :
                                                      $urandom_range(1000, 30000);
         pad_start    = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 3000);
         pad_end      = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 3000);
         audio_length = ($urandom_range(0, 3) == 0) ? $urandom :
                                                      $urandom_range(100_000, 3_000_000);
         idle_on = (round % 2 == 0) && (round != 4);
         set_config($urandom_range(0, 32768), $urandom_range(0, 12000), min_silence,
                    min_speech, max_speech, pad_start, pad_end, audio_length);
         send_stream(110, 10, 12);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------
   initial begin
      // Hold reset, then release it on a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_defaults_directed();
      test_band_and_length_split();
      test_split_at_pause();
      test_default_config_stream();
      test_short_segments_under_backpressure();
      test_length_splits();
      test_extreme_settings();
      test_mixed_settings();

      // Drain the tail: no idling, every expectation met, pipeline empty.
      idle_on = 1'b0;
      wait_segments_drained();

      $display("Sent %0d items under %0d register settings (plus reset values);",
               items_sent, config_sets);
      $display("compared %0d segments, %0d mismatches.", segments_checked, mismatch_count);
      if (mismatch_count == 0 && expected_segments.size() == 0) begin
         $display("speech_segment_tracker_top regression: pass");
      end else begin
         $display("speech_segment_tracker_top regression: fail");
      end
      $finish;
   end

   // Stop a hung run long after the slowest correct one would have ended.
   initial begin
      #(RUN_LIMIT_NS);
      $display("speech_segment_tracker_top regression: fail");
      $finish;
   end

endmodule
